// ===== src/citb_pkg.sv =====
// Shared types and constants for the cascadable interval timer block.
package citb_pkg;

    localparam int COUNT_BITS = 8;
    localparam int NUM_TIMERS = 4;
    localparam int TIDX_BITS  = 2;
    localparam int PEND_BITS  = 16;

    localparam logic [PEND_BITS-1:0]  PEND_MAX  = 16'hffff;
    localparam logic [COUNT_BITS-1:0] FF_FORCED = 8'hcc;

    // Item kinds carried on tuser
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_EXT   = 2'd3;

    // Register offsets
    localparam logic [6:0] ADDR_RUN   = 7'h20;
    localparam logic [6:0] ADDR_MATCH0 = 7'h22;
    localparam logic [6:0] ADDR_MATCH1 = 7'h23;
    localparam logic [6:0] ADDR_MODE0 = 7'h24;
    localparam logic [6:0] ADDR_FFCR  = 7'h25;
    localparam logic [6:0] ADDR_MATCH2 = 7'h26;
    localparam logic [6:0] ADDR_MATCH3 = 7'h27;
    localparam logic [6:0] ADDR_MODE1 = 7'h28;
    localparam logic [6:0] ADDR_DBUF  = 7'h29;

    // Flip-flop action codes
    localparam logic [1:0] FF_TOGGLE = 2'd0;
    localparam logic [1:0] FF_SET    = 2'd1;
    localparam logic [1:0] FF_RESET  = 2'd2;
    localparam logic [1:0] FF_NONE   = 2'd3;

    localparam logic [1:0] PAIR_MODE = 2'b01;
    localparam logic [1:0] SRC_ALT   = 2'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_COUNT,
        ST_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic                 accept;
        logic                 load;
        logic                 step;
        logic                 done;
        logic [TIDX_BITS-1:0] idx;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_tick;
        logic run;
        logic pend_nz;
        logic out_free;
    } t_sts;

endpackage

// ===== src/citb_ctrl.sv =====
// Sequencer that walks the four timers and works off pending counts.
module citb_ctrl
    import citb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_fire,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_ready
);

    t_state r_state, n_state;
    logic [TIDX_BITS-1:0] r_idx, n_idx;
    logic last_idx;

    assign last_idx = (r_idx == TIDX_BITS'(NUM_TIMERS - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_fire) begin
                    n_idx   = '0;
                    n_state = i_sts.is_tick ? ST_LOAD : ST_DONE;
                end
            end
            ST_LOAD: begin
                if (i_sts.run) begin
                    n_state = ST_COUNT;
                end else if (last_idx) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_COUNT: begin
                if (!i_sts.pend_nz) begin
                    if (last_idx) begin
                        n_state = ST_DONE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd        = '0;
        o_cmd.idx    = r_idx;
        o_cmd.accept = (r_state == ST_IDLE) && i_in_fire;
        o_cmd.load   = (r_state == ST_LOAD) && i_sts.run;
        o_cmd.step   = (r_state == ST_COUNT) && i_sts.pend_nz;
        o_cmd.done   = (r_state == ST_DONE) && i_sts.out_free;
        o_ready      = (r_state == ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

// ===== src/citb_dp.sv =====
// Timer registers, prescaler, counting step and output register.
module citb_dp
    import citb_pkg::*;
#(
    parameter int PRESCALER_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [1:0]  i_op,
    input  logic [6:0]  i_reg_addr,
    input  logic [7:0]  i_write_data,
    input  logic [11:0] i_tick_cycles,
    input  logic        i_tio_level,
    input  logic        i_out_ready,
    output t_sts        o_sts,
    output logic        o_out_valid,
    output logic [15:0] o_out_data
);

    localparam int PW = PRESCALER_BITS + 1;

    logic [PRESCALER_BITS-1:0] r_presc, n_presc;
    logic [PW-1:0]             r_newp, n_newp;
    logic [COUNT_BITS-1:0]     r_cnt [NUM_TIMERS], n_cnt [NUM_TIMERS];
    logic [PEND_BITS-1:0]      r_pend [NUM_TIMERS], n_pend [NUM_TIMERS];
    logic [COUNT_BITS-1:0]     r_match [NUM_TIMERS], n_match [NUM_TIMERS];
    logic [7:0]                r_mode [2], n_mode [2];
    logic [7:0] r_run, n_run, r_ffcr, n_ffcr, r_dbuf, n_dbuf, r_rd, n_rd;
    logic [1:0] r_ff, n_ff;
    logic       r_tio, n_tio;
    logic [3:0] r_irq, n_irq;
    logic       r_tick, n_tick;
    logic       r_ovalid, n_ovalid;
    logic [15:0] r_odata, n_odata;

    logic [TIDX_BITS-1:0] t, t_up, t_dn;
    logic [7:0]  mode;
    logic [1:0]  sel;
    logic        has_tap, pair, hit;
    logic [4:0]  tap;
    logic [PW-1:0] carry, sum;
    logic [COUNT_BITS-1:0] cnt1;

    assign t    = i_cmd.idx;
    assign t_up = {t[1], 1'b1};
    assign t_dn = {t[1], 1'b0};
    assign mode = r_mode[t[1]];
    assign pair = (mode[7:6] == PAIR_MODE);
    assign sel  = t[0] ? mode[3:2] : mode[1:0];
    assign cnt1 = r_cnt[t] + 1'b1;
    assign hit  = (cnt1 == r_match[t]);

    // Select the prescaler tap for the current timer
    always_comb begin
        has_tap = 1'b1;
        tap     = 5'd8;
        if (t[0]) begin
            unique case (sel)
                2'd0: has_tap = 1'b0;
                2'd1: tap = 5'd8;
                2'd2: tap = 5'd12;
                default: tap = 5'd16;
            endcase
        end else begin
            unique case (sel)
                2'd0: begin
                    if (t[1]) tap = 5'd7;
                    else has_tap = 1'b0;
                end
                2'd1: tap = t[1] ? 5'd7 : 5'd8;
                2'd2: tap = 5'd10;
                default: tap = 5'd12;
            endcase
        end
        carry = has_tap ? ((r_newp >> tap) - ({1'b0, r_presc} >> tap)) : '0;
        sum   = PW'(r_pend[t]) + carry;
    end

    // Next-state logic for all timer state
    always_comb begin
        n_presc = r_presc; n_newp = r_newp; n_cnt = r_cnt; n_pend = r_pend;
        n_match = r_match; n_mode = r_mode; n_run = r_run; n_ffcr = r_ffcr;
        n_dbuf = r_dbuf; n_rd = r_rd; n_ff = r_ff; n_tio = r_tio;
        n_irq = r_irq; n_tick = r_tick; n_ovalid = r_ovalid; n_odata = r_odata;

        if (i_cmd.accept) begin
            n_tick = (i_op == OP_TICK);
            n_rd   = '0;
            n_irq  = '0;
            n_newp = r_run[7] ? ({1'b0, r_presc} + PW'(i_tick_cycles))
                              : {1'b0, r_presc};
            unique case (i_op)
                OP_WRITE: begin
                    unique case (i_reg_addr)
                        ADDR_RUN: begin
                            for (int k = 0; k < NUM_TIMERS; k++) begin
                                if (!i_write_data[k]) begin
                                    n_cnt[k]  = '0;
                                    n_pend[k] = '0;
                                end
                            end
                            n_run = i_write_data;
                        end
                        ADDR_MATCH0: n_match[0] = i_write_data;
                        ADDR_MATCH1: n_match[1] = i_write_data;
                        ADDR_MATCH2: n_match[2] = i_write_data;
                        ADDR_MATCH3: n_match[3] = i_write_data;
                        ADDR_MODE0:  n_mode[0] = i_write_data;
                        ADDR_MODE1:  n_mode[1] = i_write_data;
                        ADDR_FFCR: begin
                            unique case (i_write_data[3:2])
                                FF_TOGGLE: n_ff[0] = ~r_ff[0];
                                FF_SET:    n_ff[0] = 1'b1;
                                FF_RESET:  n_ff[0] = 1'b0;
                                default:   n_ff[0] = r_ff[0];
                            endcase
                            unique case (i_write_data[7:6])
                                FF_TOGGLE: n_ff[1] = ~r_ff[1];
                                FF_SET:    n_ff[1] = 1'b1;
                                FF_RESET:  n_ff[1] = 1'b0;
                                default:   n_ff[1] = r_ff[1];
                            endcase
                            n_ffcr = i_write_data | FF_FORCED;
                        end
                        ADDR_DBUF: n_dbuf = i_write_data;
                        default: ;
                    endcase
                end
                OP_READ: begin
                    unique case (i_reg_addr)
                        ADDR_RUN:  n_rd = r_run;
                        ADDR_FFCR: n_rd = r_ffcr;
                        ADDR_DBUF: n_rd = r_dbuf;
                        default:   n_rd = '0;
                    endcase
                end
                OP_EXT: begin
                    if (r_run[0] && (r_mode[0][1:0] == SRC_ALT) && !r_tio && i_tio_level
                        && (r_pend[0] != PEND_MAX)) begin
                        n_pend[0] = r_pend[0] + 1'b1;
                    end
                    n_tio = i_tio_level;
                end
                default: ;
            endcase
        end

        // Add tap carries to the pending count, saturating
        if (i_cmd.load) begin
            n_pend[t] = (sum > PW'(PEND_MAX)) ? PEND_MAX : sum[PEND_BITS-1:0];
        end

        // Work off one pending count
        if (i_cmd.step) begin
            n_pend[t] = r_pend[t] - 1'b1;
            n_cnt[t]  = cnt1;
            if (!t[0]) begin
                if (hit) begin
                    if (r_run[t_up] && (mode[3:2] == SRC_ALT) && (r_pend[t_up] != PEND_MAX))
                        n_pend[t_up] = r_pend[t_up] + 1'b1;
                    if (!pair) begin
                        n_cnt[t] = '0;
                        n_irq[t] = 1'b1;
                    end
                end
            end else if (hit) begin
                n_cnt[t] = '0;
                n_irq[t] = 1'b1;
                // Toggle enable sits in bit 1 for timer 1 and bit 5 for timer 3
                if (r_ffcr[{t[1], 2'b01}])
                    n_ff[t[1]] = ~r_ff[t[1]];
                if (pair)
                    n_cnt[t_dn] = '0;
            end
        end

        // Hand the result to the output register
        if (i_cmd.done) begin
            if (r_tick)
                n_presc = r_newp[PRESCALER_BITS-1:0];
            n_ovalid = 1'b1;
            n_odata  = {2'b00, r_ff[1], r_ff[0], r_irq, r_rd};
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presc <= '0;
            for (int k = 0; k < NUM_TIMERS; k++) begin
                r_cnt[k]   <= '0;
                r_pend[k]  <= '0;
                r_match[k] <= '0;
            end
            r_mode[0] <= '0;
            r_mode[1] <= '0;
            r_run    <= '0;
            r_ffcr   <= FF_FORCED;
            r_dbuf   <= '0;
            r_ff     <= '0;
            r_tio    <= 1'b0;
            r_tick   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_presc <= n_presc; r_cnt <= n_cnt; r_pend <= n_pend; r_match <= n_match;
            r_mode <= n_mode; r_run <= n_run; r_ffcr <= n_ffcr; r_dbuf <= n_dbuf;
            r_ff <= n_ff; r_tio <= n_tio; r_tick <= n_tick; r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_newp  <= n_newp;
        r_rd    <= n_rd;
        r_irq   <= n_irq;
        r_odata <= n_odata;
    end

    assign o_sts.is_tick  = (i_op == OP_TICK);
    assign o_sts.run      = r_run[t];
    assign o_sts.pend_nz  = (r_pend[t] != '0);
    assign o_sts.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid    = r_ovalid;
    assign o_out_data     = r_odata;

endmodule

// ===== src/cascadable_interval_timer_block_unit.sv =====
// Top level of the cascadable interval timer block.
// Four 8-bit timers on a shared prescaler, driven by a word stream.
// Input channel: s_axis_tuser carries the item kind (tick, register write,
// register read, external input level); s_axis_tdata carries address, write
// byte, elapsed cycles and input level. Each accepted word yields exactly one
// result word on the master channel: read byte, match interrupt bits and
// both flip-flop levels after the item.
// Writes, reads and input-level words go from acceptance straight to the
// done state. A tick gives every timer a load step, and a running timer
// then works off its pending counts one at a time until they run out,
// since the single count step unit serves one timer per cycle in timer
// order 0..3.
// One word is in flight at a time; a finished result sits in the output
// register while the next word is accepted, and a stalled receiver only
// holds up completion of that next word.
// Reset (i_rst_n low, synchronous) clears all timers, the prescaler and the
// flip-flops and sets the flip-flop control register to 0xcc.
module cascadable_interval_timer_block_unit
    import citb_pkg::*;
#(
    parameter int PRESCALER_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [6:0] reg_addr, [14:7] write_data, [26:15] tick_cycles, [27] tio_level
    input  logic [31:0] s_axis_tdata,
    // [1:0] op
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] read_data, [11:8] irq_set, [12] out_ff1, [13] out_ff3
    output logic [15:0] m_axis_tdata
);

    t_cmd cmd;
    t_sts sts;
    logic in_fire;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    citb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_fire (in_fire),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_ready   (s_axis_tready)
    );

    citb_dp #(
        .PRESCALER_BITS(PRESCALER_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_op          (s_axis_tuser),
        .i_reg_addr    (s_axis_tdata[6:0]),
        .i_write_data  (s_axis_tdata[14:7]),
        .i_tick_cycles (s_axis_tdata[26:15]),
        .i_tio_level   (s_axis_tdata[27]),
        .i_out_ready   (m_axis_tready),
        .o_sts         (sts),
        .o_out_valid   (m_axis_tvalid),
        .o_out_data    (m_axis_tdata)
    );

endmodule

// ===== test/tb_top.sv =====
// Stream testbench for the cascadable interval timer block with a built-in timer predictor.
module tb_top;
    import citb_pkg::*;

    localparam int LIMIT = 4000000;

    typedef struct packed {
        logic [1:0] op;
        logic [6:0] addr;
        logic [7:0] wdata;
        logic [11:0] cyc;
        logic       lvl;
    } t_word_in;

    // Highest field first so the layout matches m_axis_tdata[13:0]
    typedef struct packed {
        logic       ff3;
        logic       ff1;
        logic [3:0] irq;
        logic [7:0] rdata;
    } t_word_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    cascadable_interval_timer_block_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Timer state mirror
    logic [23:0] tm_presc;
    logic [7:0]  tm_cnt [4];
    logic [15:0] tm_pend [4];
    logic [7:0]  tm_run;
    logic [7:0]  tm_match [4];
    logic [7:0]  tm_mode [2];
    logic [7:0]  tm_ffcr;
    logic [7:0]  tm_dbuf;
    logic [1:0]  tm_ff;
    logic        tm_tio;

    t_word_in  pending_words[$];
    t_word_out expected_results[$];
    int  errors;
    int  cycle_count;
    bit  stim_done;

    function automatic void pend_add(int t, int n);
        int v;
        v = int'(tm_pend[t]) + n;
        tm_pend[t] = (v > int'(PEND_MAX)) ? PEND_MAX : 16'(v);
    endfunction

    function automatic int tap_carries(logic [24:0] oldp, logic [24:0] newp, int tap);
        if (tap < 0) return 0;
        return int'(newp >> tap) - int'(oldp >> tap);
    endfunction

    function automatic void ff_action(int bitn, logic [1:0] code);
        case (code)
            FF_TOGGLE: tm_ff[bitn] = ~tm_ff[bitn];
            FF_SET:    tm_ff[bitn] = 1'b1;
            FF_RESET:  tm_ff[bitn] = 1'b0;
            default: ;
        endcase
    endfunction

    // Work off the low timer of a pair
    function automatic void count_low(int t, logic [24:0] oldp, logic [24:0] newp,
                                      inout logic [3:0] irq);
        logic [7:0] mode;
        logic [1:0] sel;
        int tap;
        bit pair;
        mode = tm_mode[t/2];
        sel = mode[1:0];
        pair = (mode[7:6] == PAIR_MODE);
        if (!tm_run[t]) return;
        if (t == 0) tap = (sel == 0) ? -1 : (sel == 1) ? 8 : (sel == 2) ? 10 : 12;
        else tap = (sel <= 1) ? 7 : (sel == 2) ? 10 : 12;
        pend_add(t, tap_carries(oldp, newp, tap));
        while (tm_pend[t] > 0) begin
            tm_pend[t]--;
            tm_cnt[t]++;
            if (tm_cnt[t] == tm_match[t]) begin
                if (tm_run[t+1] && mode[3:2] == SRC_ALT) pend_add(t + 1, 1);
                if (!pair) begin
                    tm_cnt[t] = 0;
                    irq[t] = 1'b1;
                end
            end
        end
    endfunction

    // Work off the high timer of a pair
    function automatic void count_high(int t, logic [24:0] oldp, logic [24:0] newp,
                                       inout logic [3:0] irq);
        logic [7:0] mode;
        logic [1:0] sel;
        int tap;
        mode = tm_mode[t/2];
        sel = mode[3:2];
        tap = (sel == 0) ? -1 : (sel == 1) ? 8 : (sel == 2) ? 12 : 16;
        if (!tm_run[t]) return;
        pend_add(t, tap_carries(oldp, newp, tap));
        while (tm_pend[t] > 0) begin
            tm_pend[t]--;
            tm_cnt[t]++;
            if (tm_cnt[t] == tm_match[t]) begin
                tm_cnt[t] = 0;
                irq[t] = 1'b1;
                if (tm_ffcr[(t == 1) ? 1 : 5]) tm_ff[(t == 1) ? 0 : 1] ^= 1'b1;
                if (mode[7:6] == PAIR_MODE) tm_cnt[t-1] = 0;
            end
        end
    endfunction

    function automatic t_word_out predict_timer(t_word_in w);
        t_word_out r;
        logic [24:0] oldp, newp;
        r = '0;
        case (w.op)
            OP_TICK: begin
                oldp = {1'b0, tm_presc};
                newp = oldp + (tm_run[7] ? w.cyc : 12'd0);
                count_low(0, oldp, newp, r.irq);
                count_high(1, oldp, newp, r.irq);
                count_low(2, oldp, newp, r.irq);
                count_high(3, oldp, newp, r.irq);
                tm_presc = newp[23:0];
            end
            OP_WRITE: begin
                case (w.addr)
                    ADDR_RUN: begin
                        for (int t = 0; t < 4; t++)
                            if (!w.wdata[t]) begin
                                tm_cnt[t] = 0;
                                tm_pend[t] = 0;
                            end
                        tm_run = w.wdata;
                    end
                    ADDR_MATCH0: tm_match[0] = w.wdata;
                    ADDR_MATCH1: tm_match[1] = w.wdata;
                    ADDR_MATCH2: tm_match[2] = w.wdata;
                    ADDR_MATCH3: tm_match[3] = w.wdata;
                    ADDR_MODE0:  tm_mode[0] = w.wdata;
                    ADDR_MODE1:  tm_mode[1] = w.wdata;
                    ADDR_FFCR: begin
                        ff_action(0, w.wdata[3:2]);
                        ff_action(1, w.wdata[7:6]);
                        tm_ffcr = w.wdata | FF_FORCED;
                    end
                    ADDR_DBUF: tm_dbuf = w.wdata;
                    default: ;
                endcase
            end
            OP_READ: begin
                if (w.addr == ADDR_RUN) r.rdata = tm_run;
                else if (w.addr == ADDR_FFCR) r.rdata = tm_ffcr;
                else if (w.addr == ADDR_DBUF) r.rdata = tm_dbuf;
            end
            default: begin
                if (tm_run[0] && tm_mode[0][1:0] == SRC_ALT && !tm_tio && w.lvl)
                    pend_add(0, 1);
                tm_tio = w.lvl;
            end
        endcase
        r.ff1 = tm_ff[0];
        r.ff3 = tm_ff[1];
        return r;
    endfunction

    function automatic t_word_in mk(logic [1:0] op, logic [6:0] a, logic [7:0] d,
                                    logic [11:0] c, logic l);
        t_word_in w;
        w.op = op; w.addr = a; w.wdata = d; w.cyc = c; w.lvl = l;
        return w;
    endfunction

    function automatic void push_wr(logic [6:0] a, logic [7:0] d);
        pending_words.push_back(mk(OP_WRITE, a, d, 12'($urandom), 1'($urandom)));
    endfunction

    function automatic void push_tick(logic [11:0] c);
        pending_words.push_back(mk(OP_TICK, 7'($urandom), 8'($urandom), c,
                                   1'($urandom)));
    endfunction

    // Small tick lengths keep counts cheap; a few long ones stress the pending logic
    function automatic logic [11:0] rand_cyc();
        int p;
        p = $urandom_range(0, 99);
        if (p < 5) return 12'hfff;
        if (p < 15) return 12'($urandom);
        return 12'($urandom_range(0, 300));
    endfunction

    function automatic void fill_stimulus();
        logic [6:0] regs [9];
        regs = '{ADDR_RUN, ADDR_MATCH0, ADDR_MATCH1, ADDR_MODE0, ADDR_FFCR,
                 ADDR_MATCH2, ADDR_MATCH3, ADDR_MODE1, ADDR_DBUF};
        // Directed: reset reads, unmapped access, extremes, ff actions, pair mode
        pending_words.push_back(mk(OP_READ, ADDR_FFCR, 8'h00, 12'h000, 1'b0));
        pending_words.push_back(mk(OP_READ, 7'h7f, 8'hff, 12'hfff, 1'b1));
        push_wr(7'h00, 8'hff);
        push_wr(7'h7f, 8'hff);
        push_wr(ADDR_DBUF, 8'hff);
        pending_words.push_back(mk(OP_READ, ADDR_DBUF, 8'h00, 12'h000, 1'b0));
        push_wr(ADDR_FFCR, {FF_SET, 2'b00, FF_SET, 2'b00});
        push_wr(ADDR_FFCR, {FF_TOGGLE, 2'b10, FF_RESET, 2'b10});
        push_wr(ADDR_FFCR, {FF_NONE, 2'b11, FF_NONE, 2'b11});
        push_wr(ADDR_MATCH0, 8'h00);
        push_wr(ADDR_MATCH1, 8'h02);
        push_wr(ADDR_MATCH2, 8'hff);
        push_wr(ADDR_MATCH3, 8'h01);
        push_wr(ADDR_MODE0, 8'h01);
        push_wr(ADDR_MODE1, 8'h40);
        push_wr(ADDR_RUN, 8'hff);
        pending_words.push_back(mk(OP_READ, ADDR_RUN, 8'h00, 12'h000, 1'b0));
        push_tick(12'hfff);
        push_tick(12'h000);
        push_wr(ADDR_MODE0, 8'h00);
        pending_words.push_back(mk(OP_EXT, 7'h00, 8'h00, 12'h000, 1'b1));
        pending_words.push_back(mk(OP_EXT, 7'h00, 8'h00, 12'h000, 1'b0));
        pending_words.push_back(mk(OP_EXT, 7'h00, 8'h00, 12'h000, 1'b1));
        push_tick(12'h001);
        push_wr(ADDR_RUN, 8'h00);
        // Random: mostly ticks, mixed with register writes, reads and input-level words
        while (pending_words.size() < 1650) begin
            int p;
            p = $urandom_range(0, 99);
            if (p < 3) push_wr(ADDR_RUN, $urandom_range(0, 1) ? 8'hff : 8'($urandom));
            else if (p < 20) push_wr(regs[$urandom_range(0, 8)],
                                     ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 4))
                                                                 : 8'($urandom));
            else if (p < 25) pending_words.push_back(mk(OP_READ,
                                 $urandom_range(0, 1) ? regs[$urandom_range(0, 8)]
                                                      : 7'($urandom),
                                 8'($urandom), 12'($urandom), 1'($urandom)));
            else if (p < 27) pending_words.push_back(mk(OP_WRITE, 7'($urandom),
                                                        8'($urandom), 12'($urandom),
                                                        1'($urandom)));
            else if (p < 45) pending_words.push_back(mk(OP_EXT, 7'($urandom),
                                                        8'($urandom), 12'($urandom),
                                                        1'($urandom)));
            else push_tick(rand_cyc());
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        tm_presc = '0; tm_run = '0; tm_ffcr = FF_FORCED; tm_dbuf = '0;
        tm_ff = '0; tm_tio = 1'b0;
        for (int t = 0; t < 4; t++) begin
            tm_cnt[t] = '0; tm_pend[t] = '0; tm_match[t] = '0;
        end
        tm_mode[0] = '0; tm_mode[1] = '0;
        errors = 0;
        stim_done = 1'b0;
        i_rst_n = 1'b0;
        fill_stimulus();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: hold each word until accepted, then wait a random gap
    int in_gap;
    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        in_gap = 0;
    end
    always @(posedge i_clk) begin
        t_word_in w;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                w = pending_words.pop_front();
                expected_results.push_back(predict_timer(w));
                s_axis_tvalid <= 1'b0;
                in_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
                if (pending_words.size() == 0) stim_done = 1'b1;
            end else if (!s_axis_tvalid && pending_words.size() > 0) begin
                if (in_gap > 0) in_gap--;
                else begin
                    w = pending_words[0];
                    s_axis_tdata <= {4'b0, w.lvl, w.cyc, w.wdata, w.addr};
                    s_axis_tuser <= w.op;
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // Monitor: random stalls on the receive side, check each result word
    int out_gap;
    initial begin
        m_axis_tready = 1'b0;
        out_gap = 0;
    end
    always @(posedge i_clk) begin
        t_word_out got, want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[13:0];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, got);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.rdata !== want.rdata)
                        $display("%0t: read_data exp %h got %h", $time, want.rdata, got.rdata);
                    if (got.irq !== want.irq)
                        $display("%0t: irq_set exp %h got %h", $time, want.irq, got.irq);
                    if (got.ff1 !== want.ff1)
                        $display("%0t: out_ff1 exp %b got %b", $time, want.ff1, got.ff1);
                    if (got.ff3 !== want.ff3)
                        $display("%0t: out_ff3 exp %b got %b", $time, want.ff3, got.ff3);
                    if (got !== want) errors++;
                end
                out_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
                m_axis_tready <= (out_gap == 0);
            end else if (out_gap > 0) begin
                out_gap--;
                m_axis_tready <= (out_gap == 0);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Completion and timeout
    initial begin
        cycle_count = 0;
        while (!(stim_done && expected_results.size() == 0) && cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        if (cycle_count >= LIMIT) begin
            $display("[cascadable_interval_timer_block_unit] ERROR");
            $finish;
        end else begin
            repeat (20) @(posedge i_clk);
            if (errors == 0 && expected_results.size() == 0)
                $display("[cascadable_interval_timer_block_unit] OK");
            else
                $display("[cascadable_interval_timer_block_unit] ERROR");
            $finish;
        end
    end

endmodule
